/* rtl/ltpf_pkg.sv */
// Shared types and constants for the line temporal persistence filter.
// Used by ltpf_line_match and line_temporal_persistence_filter; no dependencies.
`default_nettype none

package ltpf_pkg;

	// History ring geometry
	localparam int QUEUE_DEPTH     = 8;
	localparam int LINES_PER_FRAME = 16;
	localparam int RING_SLOTS      = QUEUE_DEPTH + 1;
	localparam int SLOT_W          = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int IDX_W           = (LINES_PER_FRAME > 1) ? $clog2(LINES_PER_FRAME) : 1;
	localparam int CNT_W           = $clog2(LINES_PER_FRAME + 1);
	localparam int ADDR_W          = $clog2(RING_SLOTS * LINES_PER_FRAME);
	localparam int HELD_W          = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int ANGLE_W    = 13;
	localparam int OFFSET_W   = 16;
	localparam int INLIER_W   = 16;
	localparam int HIST_W     = 4;
	localparam int MINM_W     = 4;
	localparam int ATOL_W     = 12;
	localparam int OTOL_W     = 16;
	localparam int SIC_W      = 16;
	localparam int FM_W       = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 8;

	// Angle wrap points, 1/16 degree
	localparam logic [ANGLE_W-1:0] HALF_TURN = 13'd2880;
	localparam logic [ANGLE_W-1:0] FULL_TURN = 13'd5760;

	// Register reset values
	localparam logic [HIST_W-1:0] HIST_FRAMES_RST = 4'd4;
	localparam logic [MINM_W-1:0] MIN_MATCHED_RST = 4'd2;
	localparam logic [ATOL_W-1:0] ANGLE_TOL_RST   = 12'd80;
	localparam logic [OTOL_W-1:0] OFFSET_TOL_RST  = 16'd320;
	localparam logic [SIC_W-1:0]  STRONG_INL_RST  = 16'd200;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIST_FRAMES = 3'd0,
		REG_MIN_MATCHED = 3'd1,
		REG_ANGLE_TOL   = 3'd2,
		REG_OFFSET_TOL  = 3'd3,
		REG_STRONG_INL  = 3'd4
	} cfg_reg_t;

	// One stored line
	typedef struct packed {
		logic        [ANGLE_W-1:0]  angle;
		logic signed [OFFSET_W-1:0] offset;
	} hist_entry_t;

	// Scan token entering the compare stage
	typedef struct packed {
		logic valid;
		logic last;   // final entry of the frame being scanned
	} scan_tok_t;

	// Compare stage result
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} scan_res_t;

endpackage

`default_nettype wire

/* rtl/ltpf_line_match.sv */
// Compare stage: matches one stored line against the query line.
// Depends on ltpf_pkg; result is registered in the cycle after the read data.
`default_nettype none

module ltpf_line_match (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire ltpf_pkg::scan_tok_t             tok_s1,
	input  wire ltpf_pkg::hist_entry_t           entry_s1,
	input  wire        [ltpf_pkg::ANGLE_W-1:0]   q_angle,
	input  wire signed [ltpf_pkg::OFFSET_W-1:0]  q_offset,
	input  wire        [ltpf_pkg::ATOL_W-1:0]    angle_tol,
	input  wire        [ltpf_pkg::OTOL_W-1:0]    offset_tol,
	output ltpf_pkg::scan_res_t                  res_s2
);
	import ltpf_pkg::*;

	logic        [ANGLE_W-1:0]  ang_diff;
	logic        [ANGLE_W-1:0]  ang_wrap;
	logic        [ANGLE_W-1:0]  ang_fold;
	logic signed [OFFSET_W:0]   off_diff;
	logic        [OFFSET_W:0]   off_mag;
	logic                       hit;

	// Angle distance, folded at half a turn
	always_comb begin
		ang_diff = (entry_s1.angle > q_angle) ? (entry_s1.angle - q_angle)
		                                      : (q_angle - entry_s1.angle);
		ang_wrap = (ang_diff > FULL_TURN) ? (ang_diff - FULL_TURN) : (FULL_TURN - ang_diff);
		ang_fold = (ang_diff > HALF_TURN) ? ang_wrap : ang_diff;
	end

	// Offset distance, 17-bit signed difference
	always_comb begin
		off_diff = (OFFSET_W+1)'(entry_s1.offset) - (OFFSET_W+1)'(q_offset);
		off_mag  = off_diff[OFFSET_W] ? (OFFSET_W+1)'(-off_diff) : (OFFSET_W+1)'(off_diff);
		hit      = (ang_fold <= {1'b0, angle_tol}) && (off_mag <= {1'b0, offset_tol});
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2.valid <= tok_s1.valid;
			res_s2.last  <= tok_s1.last;
			res_s2.hit   <= hit;
		end
	end

endmodule

`default_nettype wire

/* rtl/line_temporal_persistence_filter.sv */
// Top level of the line temporal persistence filter: history memory, scan sequencer,
// match accumulation and output register. Depends on ltpf_pkg and ltpf_line_match.
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser = op (1 = end of frame), tdata = line
// m_*       out  tvalid/tready      tdata = keep, frames_matched, not_stored
// cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
// A line word is compared with each line held in every searched frame; the single
// read port of the history memory scans one entry a cycle. An end-of-frame word
// gives no result. arst_n clears counters, configuration and control; the history
// memory, query and output data registers are not cleared.
// A finished result waits in the output register while the next word is scanned;
// the scan only stalls at its end if that register is still occupied.
`default_nettype none

module line_temporal_persistence_filter (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// input stream
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire [ltpf_pkg::S_TDATA_W-1:0]        s_tdata,   // angle[12:0], offset[28:13],
	                                                        // inlier_count[44:29], zero[47:45]
	input  wire                                  s_tuser,   // op
	// output stream
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [ltpf_pkg::M_TDATA_W-1:0]       m_tdata,   // keep[0], frames_matched[4:1],
	                                                        // not_stored[5], zero[7:6]
	// configuration
	input  wire                                  cfg_we,
	input  wire [ltpf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [ltpf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import ltpf_pkg::*;

	localparam int SRCH_W = (HELD_W > HIST_W) ? HELD_W : HIST_W;
	localparam int KCMP_W = (HELD_W > MINM_W) ? HELD_W : MINM_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	// Configuration registers
	logic [HIST_W-1:0] hist_frames_q;
	logic [MINM_W-1:0] min_matched_q;
	logic [ATOL_W-1:0] angle_tol_q;
	logic [OTOL_W-1:0] offset_tol_q;
	logic [SIC_W-1:0]  strong_inl_q;

	// Ring state
	state_t            state_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  cur_cnt_q;
	logic [CNT_W-1:0]  slot_cnt_q [RING_SLOTS];

	// Query line
	logic        [ANGLE_W-1:0]  q_angle_q;
	logic signed [OFFSET_W-1:0] q_offset_q;
	logic        [INLIER_W-1:0] q_inl_q;
	logic                       not_stored_q;

	// Scan sequencer
	logic [SLOT_W-1:0] scan_slot_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [HELD_W-1:0] frames_left_q;
	logic [CNT_W-1:0]  scan_n;
	logic              scan_last;
	logic              scan_issue;
	logic [ADDR_W-1:0] rd_addr;

	// Pipeline and accumulation
	scan_tok_t         tok_s1;
	hist_entry_t       rd_s1;
	scan_res_t         res_s2;
	logic              frame_hit_q;
	logic [HELD_W-1:0] matched_q;
	logic              fhit;

	// Memory
	hist_entry_t       hist_mem [RING_SLOTS*LINES_PER_FRAME];
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	hist_entry_t       wr_entry;

	// Output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// Misc
	logic              in_acc;
	logic              line_acc;
	logic              eof_acc;
	logic              store;
	logic [SLOT_W-1:0] prev_slot;
	logic [SLOT_W-1:0] next_slot;
	logic [SLOT_W-1:0] scan_prev;
	logic [SRCH_W-1:0] searched;
	logic              keep;
	logic              out_load;

	// Input decode and acceptance
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign line_acc = in_acc && !s_tuser;
	assign eof_acc  = in_acc && s_tuser;
	assign store    = (cur_cnt_q < CNT_W'(LINES_PER_FRAME));

	// Ring slot neighbors
	always_comb begin
		prev_slot = (cur_slot_q == '0) ? SLOT_W'(RING_SLOTS - 1) : (cur_slot_q - 1'b1);
		next_slot = (cur_slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : (cur_slot_q + 1'b1);
		scan_prev = (scan_slot_q == '0) ? SLOT_W'(RING_SLOTS - 1) : (scan_slot_q - 1'b1);
	end

	// Frames searched: min(history_frames, frames held)
	always_comb begin
		if (SRCH_W'(hist_frames_q) < SRCH_W'(held_q)) begin
			searched = SRCH_W'(hist_frames_q);
		end else begin
			searched = SRCH_W'(held_q);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_frames_q <= HIST_FRAMES_RST;
			min_matched_q <= MIN_MATCHED_RST;
			angle_tol_q   <= ANGLE_TOL_RST;
			offset_tol_q  <= OFFSET_TOL_RST;
			strong_inl_q  <= STRONG_INL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIST_FRAMES: hist_frames_q <= cfg_data[HIST_W-1:0];
				REG_MIN_MATCHED: min_matched_q <= cfg_data[MINM_W-1:0];
				REG_ANGLE_TOL:   angle_tol_q   <= cfg_data[ATOL_W-1:0];
				REG_OFFSET_TOL:  offset_tol_q  <= cfg_data[OTOL_W-1:0];
				REG_STRONG_INL:  strong_inl_q  <= cfg_data[SIC_W-1:0];
				default: ;
			endcase
		end
	end

	// Ring bookkeeping: store on line, advance on end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slot_q <= '0;
			held_q     <= '0;
			cur_cnt_q  <= '0;
			for (int i = 0; i < RING_SLOTS; i++) begin
				slot_cnt_q[i] <= '0;
			end
		end else if (eof_acc) begin
			cur_slot_q            <= next_slot;
			held_q                <= (held_q < HELD_W'(QUEUE_DEPTH)) ? (held_q + 1'b1) : held_q;
			slot_cnt_q[next_slot] <= '0;
			cur_cnt_q             <= '0;
		end else if (line_acc && store) begin
			cur_cnt_q              <= cur_cnt_q + 1'b1;
			slot_cnt_q[cur_slot_q] <= cur_cnt_q + 1'b1;
		end
	end

	// Query capture
	always_ff @(posedge clk) begin
		if (line_acc) begin
			q_angle_q    <= s_tdata[ANGLE_W-1:0];
			q_offset_q   <= s_tdata[ANGLE_W+OFFSET_W-1:ANGLE_W];
			q_inl_q      <= s_tdata[ANGLE_W+OFFSET_W+INLIER_W-1:ANGLE_W+OFFSET_W];
			not_stored_q <= !store;
		end
	end

	// Scan address generation
	always_comb begin
		scan_n     = slot_cnt_q[scan_slot_q];
		scan_last  = ((CNT_W'(scan_idx_q) + 1'b1) == scan_n);
		scan_issue = (state_q == ST_SEARCH) && (frames_left_q != '0) && (scan_n != '0);
		rd_addr    = ADDR_W'(scan_slot_q) * ADDR_W'(LINES_PER_FRAME) + ADDR_W'(scan_idx_q);
	end

	// Write port: the current slot is never scanned, so no hazard with reads
	always_comb begin
		wr_en           = line_acc && store;
		wr_addr         = ADDR_W'(cur_slot_q) * ADDR_W'(LINES_PER_FRAME) + ADDR_W'(cur_cnt_q);
		wr_entry.angle  = s_tdata[ANGLE_W-1:0];
		wr_entry.offset = s_tdata[ANGLE_W+OFFSET_W-1:ANGLE_W];
	end

	// History memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_entry;
		end
		if (scan_issue) begin
			rd_s1 <= hist_mem[rd_addr];
		end
	end

	// Scan token alongside read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1.valid <= scan_issue;
			tok_s1.last  <= scan_last;
		end
	end

	ltpf_line_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_s1     (tok_s1),
		.entry_s1   (rd_s1),
		.q_angle    (q_angle_q),
		.q_offset   (q_offset_q),
		.angle_tol  (angle_tol_q),
		.offset_tol (offset_tol_q),
		.res_s2     (res_s2)
	);

	// Per-frame hit accumulation
	assign fhit = frame_hit_q || res_s2.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_hit_q <= 1'b0;
			matched_q   <= '0;
		end else if (line_acc) begin
			frame_hit_q <= 1'b0;
			matched_q   <= '0;
		end else if (res_s2.valid) begin
			if (res_s2.last) begin
				matched_q   <= matched_q + HELD_W'(fhit);
				frame_hit_q <= 1'b0;
			end else begin
				frame_hit_q <= fhit;
			end
		end
	end

	// Decision and output load
	assign keep     = (q_inl_q > strong_inl_q) || (KCMP_W'(matched_q) >= KCMP_W'(min_matched_q));
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_slot_q   <= '0;
			scan_idx_q    <= '0;
			frames_left_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (line_acc) begin
						state_q       <= ST_SEARCH;
						scan_slot_q   <= prev_slot;
						scan_idx_q    <= '0;
						frames_left_q <= HELD_W'(searched);
					end
				end
				ST_SEARCH: begin
					if (frames_left_q == '0) begin
						state_q <= ST_DRAIN;
					end else if ((scan_n == '0) || scan_last) begin
						scan_idx_q    <= '0;
						scan_slot_q   <= scan_prev;
						frames_left_q <= frames_left_q - 1'b1;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!tok_s1.valid && !res_s2.valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, not_stored_q, FM_W'(matched_q), keep};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!tok_s1.valid && !res_s2.valid))
		else $error("scan pipeline busy while idle");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_slot_q) < RING_SLOTS) && (int'(held_q) <= QUEUE_DEPTH))
		else $error("ring pointer or frame count out of range");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (SRCH_W'(matched_q) <= searched))
		else $error("more matched frames than searched");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented outside of completion");

endmodule

`default_nettype wire
